/* rtl/bia_pkg.sv */
// bia_pkg: shared constants and request codes of the bitmap id allocator
// no dependencies; used by the interfaces, the controller and the top level

package bia_pkg;

	localparam int ID_W          = 8;
	localparam int REQ_W         = 2;
	localparam int BYTE_W        = 8;
	localparam int BIT_IX_W      = 3;
	localparam int BYTE_IX_W     = ID_W - BIT_IX_W;
	localparam int MAP_BYTES_DEF = 32;

	localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE0_RST = 8'h01;

	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_MARK  = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

endpackage

/* rtl/bia_req_if.sv */
// bia_req_if: request channel (valid, ready, request kind and id)
// depends on bia_pkg for field widths

interface bia_req_if;
	logic                         valid;
	logic                         ready;
	logic [bia_pkg::REQ_W-1:0]    req_type;
	logic [bia_pkg::ID_W-1:0]     item_id;

	modport source (output valid, output req_type, output item_id, input ready);
	modport sink   (input valid, input req_type, input item_id, output ready);
endinterface

/* rtl/bia_rsp_if.sv */
// bia_rsp_if: result channel (valid, ready, allocated id and query flag)
// depends on bia_pkg for field widths

interface bia_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [bia_pkg::ID_W-1:0]  result_id;
	logic                      is_marked;

	modport source (output valid, output result_id, output is_marked, input ready);
	modport sink   (input valid, input result_id, input is_marked, output ready);
endinterface

/* rtl/bitmap_id_allocator.sv */
// sequence: a clear goes straight to the result, mark and query read the addressed byte, allocate
//   scans the bytes; a result waits while the previous result is not yet taken
// throughput: one request at a time, the next is taken the cycle after the result is
//   registered; allocate is bound by the byte scan, one bitmap word read per cycle
// reset: arst_n clears all byte valid flags, so the map reads as only id 0 marked;
//   no clearing pass, a clear request does the same
// bitmap_id_allocator: top level, ties the sequencer to the bitmap ram
// depends on bia_pkg, bia_req_if, bia_rsp_if, bia_ram and bia_ctrl

module bitmap_id_allocator #(
	parameter int MAP_BYTES = bia_pkg::MAP_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bia_req_if.sink    req,
	bia_rsp_if.source  rsp
);

	// address width of the bitmap ram, one word per byte of ids
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	// ram port, driven by the sequencer
	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic [bia_pkg::BYTE_W-1:0]  ram_wdata;
	logic [bia_pkg::BYTE_W-1:0]  ram_rdata;

	// sequencer: takes a transfer, reads the addressed byte (or walks the
	// bytes from the lowest for allocate), writes the updated byte back for mark
	// and allocate and holds the result in an output register until the sink takes it
	bia_ctrl #(
		.MAP_BYTES (MAP_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	// bitmap storage, one byte per word, read data in the cycle after the address
	bia_ram #(
		.WIDTH (bia_pkg::BYTE_W),
		.DEPTH (MAP_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/bia_ram.sv */
// bia_ram: generic single-port synchronous ram, registered read
// no dependencies

module bia_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/bia_ctrl.sv */
// bia_ctrl: request sequencer, byte valid flags and result register
// depends on bia_pkg, bia_req_if and bia_rsp_if; drives one bia_ram port

module bia_ctrl #(
	parameter int MAP_BYTES = bia_pkg::MAP_BYTES_DEF,
	localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bia_req_if.sink                       req,
	bia_rsp_if.source                     rsp,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_addr,
	output logic [bia_pkg::BYTE_W-1:0]    ram_wdata,
	input  logic [bia_pkg::BYTE_W-1:0]    ram_rdata
);

	localparam logic [AW-1:0] ADDR_LAST = AW'(MAP_BYTES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                               state_q;
	bia_pkg::req_t                        req_q;
	logic [bia_pkg::BIT_IX_W-1:0]         bit_q;
	logic [AW-1:0]                        addr_q;
	logic [MAP_BYTES-1:0]                 vld_q;
	logic [bia_pkg::ID_W-1:0]             res_id_q;
	logic                                 res_mark_q;
	logic                                 out_valid_q;
	logic [bia_pkg::ID_W-1:0]             out_id_q;
	logic                                 out_mark_q;

	logic                                 in_xfer;
	logic [bia_pkg::BYTE_IX_W-1:0]        byte_ix;
	logic [bia_pkg::BYTE_IX_W:0]          byte_ix_ext;
	logic                                 in_map;
	logic [bia_pkg::BYTE_W-1:0]           cur_byte;
	logic                                 fz_found;
	logic [bia_pkg::BIT_IX_W-1:0]         fz_k;
	logic                                 out_free;

	assign req.ready   = (state_q == ST_IDLE);
	assign in_xfer     = req.valid && req.ready;
	assign byte_ix     = req.item_id[bia_pkg::ID_W-1:bia_pkg::BIT_IX_W];
	assign byte_ix_ext = {1'b0, byte_ix};
	assign in_map      = byte_ix_ext < (bia_pkg::BYTE_IX_W + 1)'(MAP_BYTES);
	assign out_free    = !out_valid_q || rsp.ready;

	// bytes never written since the last clear read as their reset value
	always_comb begin
		if (vld_q[addr_q]) begin
			cur_byte = ram_rdata;
		end else if (addr_q == '0) begin
			cur_byte = bia_pkg::BYTE0_RST;
		end else begin
			cur_byte = '0;
		end
	end

	// lowest clear bit of the byte under scan
	always_comb begin
		fz_found = 1'b0;
		fz_k     = '0;
		for (int i = bia_pkg::BYTE_W - 1; i >= 0; i--) begin
			if (!cur_byte[i]) begin
				fz_found = 1'b1;
				fz_k     = bia_pkg::BIT_IX_W'(i);
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = cur_byte | (bia_pkg::BYTE_W'(1) << bit_q);
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && req.req_type != bia_pkg::REQ_ALLOC && in_map) begin
					ram_addr = byte_ix[AW-1:0];
				end else begin
					ram_addr = '0;
				end
			end
			ST_RD: begin
				ram_we = (req_q == bia_pkg::REQ_MARK);
			end
			ST_SCAN: begin
				if (fz_found) begin
					ram_we    = 1'b1;
					ram_wdata = cur_byte | (bia_pkg::BYTE_W'(1) << fz_k);
				end else if (addr_q != ADDR_LAST) begin
					ram_addr = addr_q + AW'(1);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= bia_pkg::REQ_CLEAR;
			bit_q       <= '0;
			addr_q      <= '0;
			vld_q       <= '0;
			res_id_q    <= '0;
			res_mark_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_id_q    <= '0;
			out_mark_q  <= 1'b0;
		end else begin
			if (ram_we) begin
				vld_q[ram_addr] <= 1'b1;
			end
			// in ST_DONE the output register is refilled or still held
			if (rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						req_q      <= bia_pkg::req_t'(req.req_type);
						bit_q      <= req.item_id[bia_pkg::BIT_IX_W-1:0];
						addr_q     <= ram_addr;
						res_id_q   <= '0;
						res_mark_q <= 1'b0;
						case (req.req_type)
							bia_pkg::REQ_CLEAR: begin
								vld_q   <= '0;
								state_q <= ST_DONE;
							end
							bia_pkg::REQ_ALLOC: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= in_map ? ST_RD : ST_DONE;
							end
						endcase
					end
				end
				ST_RD: begin
					if (req_q == bia_pkg::REQ_QUERY) begin
						res_mark_q <= cur_byte[bit_q];
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (fz_found) begin
						res_id_q <= {bia_pkg::BYTE_IX_W'(addr_q), fz_k};
						state_q  <= ST_DONE;
					end else if (addr_q == ADDR_LAST) begin
						state_q <= ST_DONE;
					end else begin
						addr_q <= ram_addr;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_id_q    <= res_id_q;
						out_mark_q  <= res_mark_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.result_id = out_id_q;
	assign rsp.is_marked = out_mark_q;

endmodule
